### rtl/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types, constants and helpers for the barometric pressure
// compensation pipeline.
// ----------------------------------------------------------------------------
package bpc_pkg;

	// configuration port
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OVERSAMPLING = 2'd0,
		CFG_CAL_A        = 2'd1,
		CFG_CAL_B        = 2'd2,
		CFG_CAL_C        = 2'd3
	} cfg_reg_t;

	// field widths
	localparam int UT_W   = 16;
	localparam int UP_W   = 24;
	localparam int TEMP_W = 16;
	localparam int PRES_W = 18;

	// restoring divider geometry
	localparam int NUM_W     = 32;
	localparam int DEN_W     = 19;
	localparam int DIV_STEPS = NUM_W;

	// compensation constants
	localparam logic signed [63:0] B6_OFFSET  = 64'sd4000;
	localparam logic [11:0]        P_SQ_COEF  = 12'd3038;
	localparam logic [12:0]        P_LIN_COEF = 13'd7357;
	localparam logic signed [63:0] P_OFFSET   = 64'sd3791;
	localparam logic [15:0]        B7_SCALE   = 16'd50000;
	localparam logic signed [63:0] X3_BIAS    = 64'sd32768;
	localparam logic signed [63:0] TEMP_MAX   = 64'sd32767;
	localparam logic signed [63:0] TEMP_MIN   = -64'sd32768;
	localparam logic signed [63:0] PRES_MAX   = 64'sd262143;

	typedef struct packed {
		logic [DEN_W-1:0] rem;
		logic [NUM_W-1:0] num;
	} div_state_t;

	// sideband through the temperature divider
	typedef struct packed {
		logic               neg;
		logic               fault;
		logic signed [17:0] x1;
		logic [UP_W-1:0]    up;
	} tside_t;

	// sideband through the pressure path
	typedef struct packed {
		logic                     fault;
		logic                     shift;
		logic signed [TEMP_W-1:0] t;
		logic [UP_W-1:0]          up;
	} ctl_t;

	// signed divide by 2^k, truncating toward zero
	function automatic logic signed [63:0] sdiv_pow2(input logic signed [63:0] v,
			input int unsigned k);
		logic signed [63:0] bias;
		bias = v[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
		return (v + bias) >>> k;
	endfunction

	// one restoring division step: one quotient bit
	function automatic div_state_t div_step(input div_state_t s, input logic [DEN_W-1:0] dv);
		logic [DEN_W:0] tr;
		logic           ge;
		div_state_t     r;
		tr    = {s.rem, s.num[NUM_W-1]};
		ge    = (tr >= {1'b0, dv});
		r.rem = ge ? DEN_W'(tr - {1'b0, dv}) : tr[DEN_W-1:0];
		r.num = {s.num[NUM_W-2:0], ge};
		return r;
	endfunction

endpackage

### rtl/barometric_pressure_compensation_unit.sv
// ----------------------------------------------------------------------------
// barometric_pressure_compensation_unit
// Fixed-integer temperature and pressure compensation, fully pipelined.
// ----------------------------------------------------------------------------
// An item (raw temperature, raw pressure) is taken on every cycle that start
// is high; busy is always low. Each result leaves as a one-cycle done strobe
// in order, one result per cycle at full rate; the receiver must take it in
// that cycle. The pipeline is made of the two 32-stage restoring dividers
// (one quotient bit per stage) plus eighteen arithmetic stages. Calibration
// and oversampling are written through the cfg port; the user must do so only
// while no item is in flight, as the block does not enforce it. A zero divisor
// gives divide_fault with both other fields zero.
module barometric_pressure_compensation_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [bpc_pkg::UT_W-1:0]           raw_temperature,
	input  logic [bpc_pkg::UP_W-1:0]           raw_pressure,
	input  logic                               cfg_we,
	input  logic [bpc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bpc_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic                               done,
	output logic signed [bpc_pkg::TEMP_W-1:0]  temperature_tenths,
	output logic [bpc_pkg::PRES_W-1:0]         pressure_pa,
	output logic                               divide_fault
);
	import bpc_pkg::*;

	// configuration registers
	logic [1:0]  oss_q;
	logic [63:0] cal_a_q;
	logic [63:0] cal_b_q;
	logic [47:0] cal_c_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oss_q   <= '0;
			cal_a_q <= '0;
			cal_b_q <= '0;
			cal_c_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_OVERSAMPLING: oss_q   <= cfg_data[1:0];
				CFG_CAL_A:        cal_a_q <= cfg_data;
				CFG_CAL_B:        cal_b_q <= cfg_data;
				CFG_CAL_C:        cal_c_q <= cfg_data[47:0];
				default:          ;
			endcase
		end
	end

	// calibration words
	logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
	logic [15:0]        ac4, ac5, ac6;

	assign ac1 = $signed(cal_a_q[15:0]);
	assign ac2 = $signed(cal_a_q[31:16]);
	assign ac3 = $signed(cal_a_q[47:32]);
	assign ac4 = cal_a_q[63:48];
	assign ac5 = cal_b_q[15:0];
	assign ac6 = cal_b_q[31:16];
	assign b1  = $signed(cal_b_q[47:32]);
	assign b2  = $signed(cal_b_q[63:48]);
	assign mc  = $signed(cal_c_q[31:16]);
	assign md  = $signed(cal_c_q[47:32]);

	assign busy = 1'b0;

	// s1: ut - ac6, oversampling shift
	logic               v_s1;
	logic signed [16:0] dt_s1;
	logic [UP_W-1:0]    up_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else         v_s1 <= start & ~busy;
	end

	always_ff @(posedge clk) begin
		dt_s1 <= $signed({1'b0, raw_temperature}) - $signed({1'b0, ac6});
		up_s1 <= UP_W'(raw_pressure >> (4'd8 - {2'b00, oss_q}));
	end

	// s2: times ac5
	logic               v_s2;
	logic signed [33:0] prod_s2;
	logic [UP_W-1:0]    up_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else         v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		prod_s2 <= dt_s1 * $signed({1'b0, ac5});
		up_s2   <= up_s1;
	end

	// s3: x1 and the temperature divisor
	logic               v_s3;
	logic signed [17:0] x1_s3;
	logic signed [18:0] den_s3;
	logic [UP_W-1:0]    up_s3;
	logic signed [17:0] x1_c;

	assign x1_c = 18'(sdiv_pow2(64'(prod_s2), 15));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else         v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		x1_s3  <= x1_c;
		den_s3 <= 19'(x1_c) + 19'(md);
		up_s3  <= up_s2;
	end

	// temperature divider: stage 0 loads magnitudes, stages 1..32 step
	logic             tdv_v_s  [DIV_STEPS+1];
	div_state_t       tdv_st_s [DIV_STEPS+1];
	logic [DEN_W-1:0] tdv_dv_s [DIV_STEPS+1];
	tside_t           tdv_sd_s [DIV_STEPS+1];

	logic [DEN_W-1:0] den_abs;
	logic [16:0]      mc_abs;

	assign den_abs = den_s3[18] ? DEN_W'(-den_s3) : DEN_W'(den_s3);
	assign mc_abs  = mc[15] ? 17'(-17'(mc)) : 17'(mc);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tdv_v_s[0] <= 1'b0;
		else         tdv_v_s[0] <= v_s3;
	end

	always_ff @(posedge clk) begin
		tdv_st_s[0].rem   <= '0;
		tdv_st_s[0].num   <= {4'b0000, mc_abs, 11'b0};
		tdv_dv_s[0]       <= den_abs;
		tdv_sd_s[0].neg   <= mc[15] ^ den_s3[18];
		tdv_sd_s[0].fault <= (den_s3 == '0);
		tdv_sd_s[0].x1    <= x1_s3;
		tdv_sd_s[0].up    <= up_s3;
	end

	for (genvar i = 1; i <= DIV_STEPS; i++) begin : g_tdiv
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) tdv_v_s[i] <= 1'b0;
			else         tdv_v_s[i] <= tdv_v_s[i-1];
		end

		always_ff @(posedge clk) begin
			tdv_st_s[i] <= div_step(tdv_st_s[i-1], tdv_dv_s[i-1]);
			tdv_dv_s[i] <= tdv_dv_s[i-1];
			tdv_sd_s[i] <= tdv_sd_s[i-1];
		end
	end

	// s5: signed x2, b5
	logic               v_s5;
	logic signed [27:0] b5_s5;
	ctl_t               ctl_s5;
	logic [27:0]        tq_mag;
	logic signed [27:0] x2_c;

	assign tq_mag = 28'(tdv_st_s[DIV_STEPS].num[26:0]);
	assign x2_c   = tdv_sd_s[DIV_STEPS].neg ? -$signed(tq_mag) : $signed(tq_mag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else         v_s5 <= tdv_v_s[DIV_STEPS];
	end

	always_ff @(posedge clk) begin
		b5_s5        <= 28'(tdv_sd_s[DIV_STEPS].x1) + x2_c;
		ctl_s5.fault <= tdv_sd_s[DIV_STEPS].fault;
		ctl_s5.shift <= 1'b0;
		ctl_s5.t     <= '0;
		ctl_s5.up    <= tdv_sd_s[DIV_STEPS].up;
	end

	// s6: temperature result, b6
	logic               v_s6;
	logic signed [27:0] b6_s6;
	ctl_t               ctl_s6;
	logic signed [63:0] t_full;
	logic signed [TEMP_W-1:0] t_sat;

	assign t_full = sdiv_pow2(64'(b5_s5) + 64'sd8, 4);

	always_comb begin
		if (t_full > TEMP_MAX)      t_sat = TEMP_W'(TEMP_MAX);
		else if (t_full < TEMP_MIN) t_sat = TEMP_W'(TEMP_MIN);
		else                        t_sat = TEMP_W'(t_full);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else         v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		b6_s6        <= 28'(64'(b5_s5) - B6_OFFSET);
		ctl_s6.fault <= ctl_s5.fault;
		ctl_s6.shift <= ctl_s5.shift;
		ctl_s6.t     <= t_sat;
		ctl_s6.up    <= ctl_s5.up;
	end

	// s7: b6 squared, ac2*b6, ac3*b6
	logic               v_s7;
	logic signed [55:0] sqf_s7;
	logic signed [43:0] ac2b6_s7;
	logic signed [43:0] ac3b6_s7;
	ctl_t               ctl_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else         v_s7 <= v_s6;
	end

	always_ff @(posedge clk) begin
		sqf_s7   <= b6_s6 * b6_s6;
		ac2b6_s7 <= ac2 * b6_s6;
		ac3b6_s7 <= ac3 * b6_s6;
		ctl_s7   <= ctl_s6;
	end

	// s8: scale the products
	logic               v_s8;
	logic [41:0]        sq_s8;
	logic signed [32:0] x2a_s8;
	logic signed [30:0] x1c_s8;
	ctl_t               ctl_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s8 <= 1'b0;
		else         v_s8 <= v_s7;
	end

	always_ff @(posedge clk) begin
		sq_s8  <= sqf_s7[53:12];
		x2a_s8 <= 33'(sdiv_pow2(64'(ac2b6_s7), 11));
		x1c_s8 <= 31'(sdiv_pow2(64'(ac3b6_s7), 13));
		ctl_s8 <= ctl_s7;
	end

	// s9: b2*sq and b1*sq
	logic               v_s9;
	logic signed [58:0] b2sq_s9;
	logic signed [58:0] b1sq_s9;
	logic signed [32:0] x2a_s9;
	logic signed [30:0] x1c_s9;
	ctl_t               ctl_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s9 <= 1'b0;
		else         v_s9 <= v_s8;
	end

	always_ff @(posedge clk) begin
		b2sq_s9 <= b2 * $signed({1'b0, sq_s8});
		b1sq_s9 <= b1 * $signed({1'b0, sq_s8});
		x2a_s9  <= x2a_s8;
		x1c_s9  <= x1c_s8;
		ctl_s9  <= ctl_s8;
	end

	// s10: the two x3 sums
	logic               v_s10;
	logic signed [48:0] x3a_s10;
	logic signed [43:0] x3p_s10;
	ctl_t               ctl_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s10 <= 1'b0;
		else         v_s10 <= v_s9;
	end

	always_ff @(posedge clk) begin
		x3a_s10 <= 49'(sdiv_pow2(64'(b2sq_s9), 11)) + 49'(x2a_s9);
		x3p_s10 <= 44'(sdiv_pow2(64'(b1sq_s9), 16)) + 44'(x1c_s9);
		ctl_s10 <= ctl_s9;
	end

	// s11: b3 and the b4 operand, both modulo 2^32
	logic               v_s11;
	logic [31:0]        b3_s11;
	logic [31:0]        w_s11;
	ctl_t               ctl_s11;
	logic signed [63:0] b3_pre;
	logic signed [63:0] b3_full;
	logic signed [63:0] x3_full;

	assign b3_pre  = (64'(ac1) * 64'sd4 + 64'(x3a_s10)) <<< oss_q;
	assign b3_full = sdiv_pow2(b3_pre + 64'sd2, 2);
	assign x3_full = sdiv_pow2(64'(x3p_s10) + 64'sd2, 2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s11 <= 1'b0;
		else         v_s11 <= v_s10;
	end

	always_ff @(posedge clk) begin
		b3_s11  <= b3_full[31:0];
		w_s11   <= 32'(x3_full + X3_BIAS);
		ctl_s11 <= ctl_s10;
	end

	// s12: b4 and up - b3
	logic        v_s12;
	logic [16:0] b4_s12;
	logic [31:0] diff_s12;
	ctl_t        ctl_s12;
	logic [47:0] b4_prod;

	assign b4_prod = ac4 * w_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s12 <= 1'b0;
		else         v_s12 <= v_s11;
	end

	always_ff @(posedge clk) begin
		b4_s12   <= b4_prod[31:15];
		diff_s12 <= 32'(ctl_s11.up) - b3_s11;
		ctl_s12  <= ctl_s11;
	end

	// s13: b7 modulo 2^32, pressure divisor check
	logic        v_s13;
	logic [31:0] b7_s13;
	logic [16:0] b4_s13;
	ctl_t        ctl_s13;
	logic [15:0] b7_scale;
	logic [47:0] b7_prod;

	assign b7_scale = B7_SCALE >> oss_q;
	assign b7_prod  = diff_s12 * b7_scale;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s13 <= 1'b0;
		else         v_s13 <= v_s12;
	end

	always_ff @(posedge clk) begin
		b7_s13        <= b7_prod[31:0];
		b4_s13        <= b4_s12;
		ctl_s13.fault <= ctl_s12.fault | (b4_s12 == '0);
		ctl_s13.shift <= ctl_s12.shift;
		ctl_s13.t     <= ctl_s12.t;
		ctl_s13.up    <= ctl_s12.up;
	end

	// pressure divider: b7*2/b4 or (b7/b4)*2 by the top bit of b7
	logic             pdv_v_s  [DIV_STEPS+1];
	div_state_t       pdv_st_s [DIV_STEPS+1];
	logic [DEN_W-1:0] pdv_dv_s [DIV_STEPS+1];
	ctl_t             pdv_sd_s [DIV_STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pdv_v_s[0] <= 1'b0;
		else         pdv_v_s[0] <= v_s13;
	end

	always_ff @(posedge clk) begin
		pdv_st_s[0].rem   <= '0;
		pdv_st_s[0].num   <= b7_s13[31] ? b7_s13 : {b7_s13[30:0], 1'b0};
		pdv_dv_s[0]       <= DEN_W'(b4_s13);
		pdv_sd_s[0].fault <= ctl_s13.fault;
		pdv_sd_s[0].shift <= b7_s13[31];
		pdv_sd_s[0].t     <= ctl_s13.t;
		pdv_sd_s[0].up    <= ctl_s13.up;
	end

	for (genvar i = 1; i <= DIV_STEPS; i++) begin : g_pdiv
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) pdv_v_s[i] <= 1'b0;
			else         pdv_v_s[i] <= pdv_v_s[i-1];
		end

		always_ff @(posedge clk) begin
			pdv_st_s[i] <= div_step(pdv_st_s[i-1], pdv_dv_s[i-1]);
			pdv_dv_s[i] <= pdv_dv_s[i-1];
			pdv_sd_s[i] <= pdv_sd_s[i-1];
		end
	end

	// s15: raw pressure quotient
	logic        v_s15;
	logic [32:0] q_s15;
	ctl_t        ctl_s15;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s15 <= 1'b0;
		else         v_s15 <= pdv_v_s[DIV_STEPS];
	end

	always_ff @(posedge clk) begin
		q_s15   <= pdv_sd_s[DIV_STEPS].shift ? {pdv_st_s[DIV_STEPS].num, 1'b0}
		                                     : {1'b0, pdv_st_s[DIV_STEPS].num};
		ctl_s15 <= pdv_sd_s[DIV_STEPS];
	end

	// s16: (p/256)^2 and 7357*p
	logic        v_s16;
	logic [49:0] pdsq_s16;
	logic [45:0] x2m_s16;
	logic [32:0] q_s16;
	ctl_t        ctl_s16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s16 <= 1'b0;
		else         v_s16 <= v_s15;
	end

	always_ff @(posedge clk) begin
		pdsq_s16 <= q_s15[32:8] * q_s15[32:8];
		x2m_s16  <= q_s15 * P_LIN_COEF;
		q_s16    <= q_s15;
		ctl_s16  <= ctl_s15;
	end

	// s17: times 3038, negated linear term
	logic               v_s17;
	logic [61:0]        m_s17;
	logic signed [30:0] x2_s17;
	logic [32:0]        q_s17;
	ctl_t               ctl_s17;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s17 <= 1'b0;
		else         v_s17 <= v_s16;
	end

	always_ff @(posedge clk) begin
		m_s17   <= pdsq_s16 * P_SQ_COEF;
		x2_s17  <= -$signed({1'b0, x2m_s16[45:16]});
		q_s17   <= q_s16;
		ctl_s17 <= ctl_s16;
	end

	// s18: final correction, saturation, result registers
	logic                     done_q;
	logic signed [TEMP_W-1:0] temp_q;
	logic [PRES_W-1:0]        pres_q;
	logic                     fault_q;
	logic signed [63:0]       corr_sum;
	logic signed [63:0]       p_full;
	logic [PRES_W-1:0]        p_sat;

	assign corr_sum = 64'($signed({1'b0, m_s17[61:16]})) + 64'(x2_s17) + P_OFFSET;
	assign p_full   = $signed({31'b0, q_s17}) + sdiv_pow2(corr_sum, 4);

	always_comb begin
		if (p_full < 64'sd0)         p_sat = '0;
		else if (p_full > PRES_MAX)  p_sat = PRES_W'(PRES_MAX);
		else                         p_sat = PRES_W'(p_full);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else         done_q <= v_s17;
	end

	always_ff @(posedge clk) begin
		fault_q <= ctl_s17.fault;
		temp_q  <= ctl_s17.fault ? '0 : ctl_s17.t;
		pres_q  <= ctl_s17.fault ? '0 : p_sat;
	end

	assign done               = done_q;
	assign temperature_tenths = temp_q;
	assign pressure_pa        = pres_q;
	assign divide_fault       = fault_q;

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the barometric pressure compensation unit. A
// scoreboard predicts every result from its own copy of the calibration
// and compares the result strobes in order, while the driver steps through
// calibration sets, oversampling settings and random sender gaps.
// ----------------------------------------------------------------------------
module tb_top;
	import bpc_pkg::*;

	typedef struct {
		logic signed [TEMP_W-1:0] temp;
		logic [PRES_W-1:0]        pres;
		logic                     fault;
	} reading_t;

	// result predictor and in-order store of expected readings
	class compensation_scoreboard;
		logic [1:0]  oss;
		logic [63:0] cal_a, cal_b;
		logic [47:0] cal_c;
		reading_t    expected_q[$];
		int          errors, items, results, faults;

		function void write_reg(cfg_reg_t idx, logic [63:0] value);
			case (idx)
				CFG_OVERSAMPLING: oss = value[1:0];
				CFG_CAL_A: cal_a = value;
				CFG_CAL_B: cal_b = value;
				CFG_CAL_C: cal_c = value[47:0];
				default: ;
			endcase
		endfunction

		function reading_t compensate(logic [UT_W-1:0] ut_raw, logic [UP_W-1:0] up_raw);
			longint ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
			longint ut, x1, x2, x3, b3, b5, b6, sq, p, t;
			bit [63:0] up, b4, b7, q, m32;
			reading_t r;
			m32 = 64'hFFFF_FFFF;
			ac1 = longint'($signed(cal_a[15:0]));
			ac2 = longint'($signed(cal_a[31:16]));
			ac3 = longint'($signed(cal_a[47:32]));
			ac4 = longint'(cal_a[63:48]);
			ac5 = longint'(cal_b[15:0]);
			ac6 = longint'(cal_b[31:16]);
			b1  = longint'($signed(cal_b[47:32]));
			b2  = longint'($signed(cal_b[63:48]));
			mc  = longint'($signed(cal_c[31:16]));
			md  = longint'($signed(cal_c[47:32]));
			ut  = longint'(ut_raw);
			up  = 64'(up_raw) >> (8 - oss);
			r.temp = '0;
			r.pres = '0;
			r.fault = 1'b1;
			// temperature
			x1 = ((ut - ac6) * ac5) / 32768;
			if (x1 + md == 0) return r;
			x2 = (mc * 2048) / (x1 + md);
			b5 = x1 + x2;
			t = (b5 + 8) / 16;
			// pressure
			b6 = b5 - 4000;
			sq = (b6 * b6) / 4096;
			x1 = (b2 * sq) / 2048;
			x2 = (ac2 * b6) / 2048;
			x3 = x1 + x2;
			b3 = ((ac1 * 4 + x3) * (longint'(1) << oss) + 2) / 4;
			x1 = (ac3 * b6) / 8192;
			x2 = (b1 * sq) / 65536;
			x3 = ((x1 + x2) + 2) / 4;
			b4 = ((64'(ac4) * (64'(x3 + 32768) & m32)) & m32) / 64'd32768;
			if (b4 == 0) return r;
			b7 = (((up - (64'(b3) & m32)) & m32) * (64'd50000 >> oss)) & m32;
			if (b7 < 64'h8000_0000) q = (b7 * 2) / b4;
			else q = (b7 / b4) * 2;
			p = longint'(q);
			x1 = (p / 256) * (p / 256);
			x1 = (x1 * 3038) / 65536;
			x2 = (-7357 * p) / 65536;
			p = p + (x1 + x2 + 3791) / 16;
			if (t > 32767) t = 32767;
			if (t < -32768) t = -32768;
			if (p < 0) p = 0;
			if (p > 262143) p = 262143;
			r.temp = t[15:0];
			r.pres = p[17:0];
			r.fault = 1'b0;
			return r;
		endfunction

		function void note_item(logic [UT_W-1:0] ut, logic [UP_W-1:0] up);
			reading_t r;
			r = compensate(ut, up);
			items++;
			if (r.fault) faults++;
			expected_q.push_back(r);
		endfunction

		function void check_result(logic signed [TEMP_W-1:0] temp, logic [PRES_W-1:0] pres,
				logic fault);
			reading_t e;
			results++;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result temp=%0d pres=%0d fault=%0b",
					$time, temp, pres, fault);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (temp !== e.temp) begin
				$display("%0t: temperature_tenths expected %0d got %0d", $time, e.temp, temp);
				errors++;
			end
			if (pres !== e.pres) begin
				$display("%0t: pressure_pa expected %0d got %0d", $time, e.pres, pres);
				errors++;
			end
			if (fault !== e.fault) begin
				$display("%0t: divide_fault expected %0b got %0b", $time, e.fault, fault);
				errors++;
			end
		endfunction
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic                     busy;
	logic [UT_W-1:0]          raw_temperature = '0;
	logic [UP_W-1:0]          raw_pressure = '0;
	logic                     cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index = '0;
	logic [CFG_DATA_W-1:0]    cfg_data = '0;
	logic                     done;
	logic signed [TEMP_W-1:0] temperature_tenths;
	logic [PRES_W-1:0]        pressure_pa;
	logic                     divide_fault;

	compensation_scoreboard sb = new();
	int idle_pct = 0;
	int sets = 0;

	barometric_pressure_compensation_unit dut (.*);

	always #5 clk = ~clk;

	// accepted items and result strobes
	always @(posedge clk) begin
		if (arst_n && start && !busy) sb.note_item(raw_temperature, raw_pressure);
		if (arst_n && done) sb.check_result(temperature_tenths, pressure_pa, divide_fault);
	end

	task automatic write_reg(cfg_reg_t idx, logic [63:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		sb.write_reg(idx, value);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// hold off until every result is back, then let the pipe settle
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (90) @(posedge clk);
	endtask

	// vendor-like calibration, exact or with random spread, raw random words, or all ones
	task automatic load_cal(int kind, logic [1:0] oss);
		logic [15:0] w[11];
		int spread;
		spread = $urandom_range(2000);
		w = '{16'd408, -16'sd72, -16'sd14383, 16'd32741, 16'd32757, 16'd23153,
			16'd6190, 16'd4, -16'sd32768, -16'sd8711, 16'd2868};
		foreach (w[i]) begin
			if (kind == 1) w[i] = 16'($urandom);
			else if (kind == 2) w[i] = 16'hFFFF;
			else if (kind == 0) w[i] = 16'(w[i] + $urandom_range(2 * spread) - spread);
		end
		write_reg(CFG_OVERSAMPLING, 64'(oss));
		write_reg(CFG_CAL_A, {w[3], w[2], w[1], w[0]});
		write_reg(CFG_CAL_B, {w[7], w[6], w[5], w[4]});
		write_reg(CFG_CAL_C, {16'hFFFF, w[10], w[9], w[8]});
		sets++;
	endtask

	task automatic send_item(logic [UT_W-1:0] ut, logic [UP_W-1:0] up);
		start <= 1'b1;
		raw_temperature <= ut;
		raw_pressure <= up;
		do @(posedge clk); while (busy);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
	endtask

	task automatic send_random(int count);
		repeat (count) begin
			if ($urandom_range(1)) send_item(UT_W'($urandom_range(40000, 20000)),
				UP_W'($urandom));
			else send_item(UT_W'($urandom), UP_W'($urandom));
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		// reset calibration: every word zero, so the temperature divisor is zero
		@(posedge clk);
		send_item('0, '0);
		send_item('1, '1);
		drain();
		// vendor calibration, raw field extremes, all oversampling settings
		for (int o = 0; o < 4; o++) begin
			load_cal(3, o[1:0]);
			send_item('0, '0);
			send_item('1, '1);
			send_item(16'd27898, 24'h5D2300);
			send_item(16'h8000, 24'h800000);
			drain();
		end
		// AC4 zero gives a zero pressure divisor
		load_cal(3, 2'd1);
		write_reg(CFG_CAL_A, 64'h0000_C7AF_FFB8_0198);
		send_item(16'd27898, 24'h5D2300);
		send_item('1, '0);
		drain();
		// all-ones calibration drives the saturation paths
		load_cal(2, 2'd3);
		send_random(3);
		drain();
		// random part: gaps at 29, then 81, then 0 percent
		for (int blk = 0; blk < 20; blk++) begin
			idle_pct = (blk < 7) ? 29 : (blk < 14) ? 81 : 0;
			load_cal(($urandom_range(9) < 7) ? 0 : 1, 2'($urandom_range(3)));
			send_random(25);
			drain();
		end
		$display("covered %0d items over %0d calibration sets, %0d divide faults",
			sb.items, sets, sb.faults);
		$display("%0d results checked, %0d mismatches", sb.results, sb.errors);
		if (sb.errors == 0 && sb.expected_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// watchdog
	initial begin
		#2ms;
		$display("timeout with %0d results outstanding", sb.expected_q.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule
